// ===== rtl/scs_pkg.sv =====
// scs_pkg: shared types, widths and codes for the simplex causal signature unit
// depends on nothing; imported by every module under rtl/
package scs_pkg;

  // lattice coordinate width; four coordinates packed t,x,y,z from the top
  localparam int COORD_BITS = 8;
  localparam int PACK_W     = 4 * COORD_BITS;

  // datapath widths, all derived from the coordinate width
  localparam int DW  = COORD_BITS + 1;       // signed coordinate difference
  localparam int PW  = 2 * COORD_BITS + 1;   // signed product of two differences
  localparam int NW  = 2 * COORD_BITS + 3;   // signed dot product u.w
  localparam int DNW = 2 * COORD_BITS + 2;   // squared base length u.u
  localparam int VW  = 3 * COORD_BITS + 4;   // signed scaled connecting vector
  localparam int MW  = 3 * COORD_BITS + 3;   // magnitude of a vector component
  localparam int SQW = 2 * MW;               // square of one component
  localparam int SPW = SQW + 2;              // sum of three squares

  // clock edges from taking an item to taking its result
  localparam int LATENCY = 7;

  typedef enum logic {
    OP_EDGE     = 1'b0,
    OP_TRIANGLE = 1'b1
  } op_t;

  // what the back stages do with an item
  typedef enum logic [1:0] {
    KIND_VEC,    // classify the carried vector
    KIND_PROJ,   // project corner onto base, then classify
    KIND_TIME,   // all corner time differences nonzero
    KIND_DEGEN   // base edge of zero length
  } kind_t;

  localparam logic signed [1:0] SIG_SPACE = 2'sd1;
  localparam logic signed [1:0] SIG_TIME  = -2'sd1;
  localparam logic signed [1:0] SIG_LIGHT = 2'sd0;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
  } scs_in_t;

  typedef struct packed {
    logic signed [1:0] signature;
    logic              degenerate;
    logic              projection_outside;
  } scs_out_t;

  // after base selection: base vector u and corner vector w
  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [3:0][DW-1:0]   u;
    logic [3:0][DW-1:0]   w;
  } scs_base_t;

  // after projection: component magnitudes of the vector to classify
  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic                 outside;
    logic [3:0][MW-1:0]   mag;
  } scs_mag_t;

  // one coordinate of a packed vertex; bits beyond the 32-bit word read as zero
  function automatic logic [COORD_BITS-1:0] coord(logic [31:0] v, logic [1:0] k);
    logic [PACK_W+31:0] e;
    e = {{PACK_W{1'b0}}, v};
    return e[(2'd3 - k) * COORD_BITS +: COORD_BITS];
  endfunction

  // signed difference a - b of two unsigned coordinates
  function automatic logic [DW-1:0] sdiff(logic [COORD_BITS-1:0] a,
                                          logic [COORD_BITS-1:0] b);
    return {1'b0, a} - {1'b0, b};
  endfunction

  // absolute difference of two unsigned coordinates
  function automatic logic [COORD_BITS-1:0] adiff(logic [COORD_BITS-1:0] a,
                                                  logic [COORD_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

// ===== rtl/scs_base_select.sv =====
// scs_base_select: first pipeline stage; unpacks corners, picks the base edge
// and forms the base and corner vectors; depends on scs_pkg
module scs_base_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  scs_pkg::scs_in_t   cmd,
  output scs_pkg::scs_base_t base
);
  import scs_pkg::*;

  logic [COORD_BITS-1:0] c [3][4];
  logic [COORD_BITS-1:0] dif0, dif1, dif2;
  logic [1:0]            sel, ia, ib, ic;
  scs_base_t             base_next;

  // corner unpack, time differences and base choice
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[0][k] = coord(cmd.vertex_a, 2'(k));
      c[1][k] = coord(cmd.vertex_b, 2'(k));
      c[2][k] = coord(cmd.vertex_c, 2'(k));
    end
    dif0 = adiff(c[0][0], c[1][0]);
    dif1 = adiff(c[1][0], c[2][0]);
    dif2 = adiff(c[2][0], c[0][0]);
    // strict less-than; ties go to the later edge
    if (dif0 < dif1) begin
      sel = (dif0 < dif2) ? 2'd0 : 2'd2;
    end else begin
      sel = (dif1 < dif2) ? 2'd1 : 2'd2;
    end
    case (sel)
      2'd0: begin
        ia = 2'd0; ib = 2'd1; ic = 2'd2;
      end
      2'd1: begin
        ia = 2'd1; ib = 2'd2; ic = 2'd0;
      end
      default: begin
        ia = 2'd2; ib = 2'd0; ic = 2'd1;
      end
    endcase

    base_next.valid = take;
    if (cmd.opcode == OP_EDGE) begin
      base_next.kind = KIND_VEC;
      for (int k = 0; k < 4; k++) begin
        base_next.u[k] = sdiff(c[1][k], c[0][k]);
        base_next.w[k] = '0;
      end
    end else begin
      if (dif0 != '0 && dif1 != '0 && dif2 != '0) begin
        base_next.kind = KIND_TIME;
      end else begin
        base_next.kind = KIND_PROJ;
      end
      for (int k = 0; k < 4; k++) begin
        base_next.u[k] = sdiff(c[ib][k], c[ia][k]);
        base_next.w[k] = sdiff(c[ic][k], c[ia][k]);
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else begin
      base <= base_next;
    end
  end

endmodule

// ===== rtl/scs_project.sv =====
// scs_project: four pipeline stages that project the corner onto the base edge
// and form the scaled connecting vector V = u*n - w*D; depends on scs_pkg
module scs_project (
  input  logic               clk,
  input  logic               rst,
  input  scs_pkg::scs_base_t base,
  output scs_pkg::scs_mag_t  vec
);
  import scs_pkg::*;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [3:0][DW-1:0] u;
    logic [3:0][DW-1:0] w;
    logic [3:0][PW-1:0] pn;
    logic [3:0][PW-1:0] pd;
  } s2_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic               outside;
    logic [3:0][DW-1:0] u;
    logic [3:0][DW-1:0] w;
    logic [NW-1:0]      n;
    logic [DNW-1:0]     den;
  } s3_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic               outside;
    logic [3:0][DW-1:0] u;
    logic [3:0][VW-1:0] un;
    logic [3:0][VW-1:0] wd;
  } s4_t;

  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  scs_mag_t vec_next;

  logic signed [DW-1:0] u2 [4];
  logic signed [DW-1:0] w2 [4];
  logic signed [PW-1:0] pn2 [4];
  logic signed [PW-1:0] pd2 [4];
  logic signed [NW-1:0] n3, den3;
  logic signed [VW-1:0] un4 [4];
  logic signed [VW-1:0] wd4 [4];
  logic signed [VW-1:0] d5 [4];
  logic signed [VW-1:0] a5 [4];

  // per-component products for u.w and u.u
  always_comb begin
    s2_next.valid = base.valid;
    s2_next.kind  = base.kind;
    s2_next.u     = base.u;
    s2_next.w     = base.w;
    for (int k = 0; k < 4; k++) begin
      u2[k]  = $signed(base.u[k]);
      w2[k]  = $signed(base.w[k]);
      pn2[k] = u2[k] * w2[k];
      pd2[k] = u2[k] * u2[k];
      s2_next.pn[k] = pn2[k];
      s2_next.pd[k] = pd2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s2_next;
    end
  end

  // dot products, degenerate base and foot-outside test
  always_comb begin
    n3   = $signed(s2.pn[0]) + $signed(s2.pn[1]) + $signed(s2.pn[2]) + $signed(s2.pn[3]);
    den3 = $signed(s2.pd[0]) + $signed(s2.pd[1]) + $signed(s2.pd[2]) + $signed(s2.pd[3]);
    s3_next.valid   = s2.valid;
    s3_next.u       = s2.u;
    s3_next.w       = s2.w;
    s3_next.n       = n3;
    s3_next.den     = DNW'(den3);
    s3_next.kind    = s2.kind;
    s3_next.outside = 1'b0;
    if (s2.kind == KIND_PROJ) begin
      if (den3 == '0) begin
        s3_next.kind = KIND_DEGEN;
      end else begin
        s3_next.outside = (n3 < 0) || (n3 > den3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s3_next;
    end
  end

  // scaled terms u*n and w*D
  always_comb begin
    s4_next.valid   = s3.valid;
    s4_next.kind    = s3.kind;
    s4_next.outside = s3.outside;
    s4_next.u       = s3.u;
    for (int k = 0; k < 4; k++) begin
      un4[k] = $signed(s3.u[k]) * $signed(s3.n);
      wd4[k] = $signed(s3.w[k]) * $signed({1'b0, s3.den});
      s4_next.un[k] = un4[k];
      s4_next.wd[k] = wd4[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4 <= '0;
    end else begin
      s4 <= s4_next;
    end
  end

  // connecting vector and component magnitudes; edges pass their difference
  always_comb begin
    vec_next.valid   = s4.valid;
    vec_next.outside = s4.outside;
    vec_next.kind    = (s4.kind == KIND_PROJ) ? KIND_VEC : s4.kind;
    for (int k = 0; k < 4; k++) begin
      if (s4.kind == KIND_PROJ) begin
        d5[k] = $signed(s4.un[k]) - $signed(s4.wd[k]);
      end else begin
        d5[k] = $signed(s4.u[k]);
      end
      a5[k] = d5[k][VW-1] ? -d5[k] : d5[k];
      vec_next.mag[k] = MW'(a5[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec <= '0;
    end else begin
      vec <= vec_next;
    end
  end

endmodule

// ===== rtl/scs_classify.sv =====
// scs_classify: last two pipeline stages; squares the components and compares
// space against time to give the result item; depends on scs_pkg
module scs_classify (
  input  logic              clk,
  input  logic              rst,
  input  scs_pkg::scs_mag_t vec,
  output logic              done,
  output scs_pkg::scs_out_t result
);
  import scs_pkg::*;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                outside;
    logic [3:0][SQW-1:0] sq;
  } s6_t;

  s6_t      s6, s6_next;
  scs_out_t result_next;
  logic [MW-1:0]  m6 [4];
  logic [SQW-1:0] q6 [4];
  logic [SPW-1:0] space, tm;

  // component squares
  always_comb begin
    s6_next.valid   = vec.valid;
    s6_next.kind    = vec.kind;
    s6_next.outside = vec.outside;
    for (int k = 0; k < 4; k++) begin
      m6[k] = vec.mag[k];
      q6[k] = m6[k] * m6[k];
      s6_next.sq[k] = q6[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6 <= '0;
    end else begin
      s6 <= s6_next;
    end
  end

  // space sum against time square
  always_comb begin
    space = SPW'(s6.sq[1]) + SPW'(s6.sq[2]) + SPW'(s6.sq[3]);
    tm    = SPW'(s6.sq[0]);
    result_next.degenerate         = 1'b0;
    result_next.projection_outside = 1'b0;
    case (s6.kind)
      KIND_VEC: begin
        result_next.projection_outside = s6.outside;
        if (space > tm) begin
          result_next.signature = SIG_SPACE;
        end else if (space < tm) begin
          result_next.signature = SIG_TIME;
        end else begin
          result_next.signature = SIG_LIGHT;
        end
      end
      KIND_TIME: begin
        result_next.signature = SIG_TIME;
      end
      KIND_DEGEN: begin
        result_next.signature  = SIG_LIGHT;
        result_next.degenerate = 1'b1;
      end
      default: begin
        result_next.signature = SIG_LIGHT;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s6.valid;
    end
    result <= result_next;
  end

endmodule

// ===== rtl/simplex_causal_signature_unit.sv =====
// simplex_causal_signature_unit: exact causal classification of an edge or triangle
// result: strobed on done once its item has passed through every pipeline stage
// throughput: one item per cycle outside reset; a 7-stage pipeline with no feedback sets the pace
// busy follows rst only; the result receiver cannot stall and is never waited on
// reset: synchronous, active high; clears all stage valid bits, no items in flight
// depends on scs_pkg, scs_base_select, scs_project, scs_classify
module simplex_causal_signature_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  scs_pkg::scs_in_t  cmd,
  output logic              done,
  output scs_pkg::scs_out_t result
);
  import scs_pkg::*;

  scs_base_t base;
  scs_mag_t  vec;
  logic      take;

  // an item is taken on any cycle that start is high outside reset
  assign busy = rst;
  assign take = start & ~busy;

  scs_base_select u_base (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .cmd  (cmd),
    .base (base)
  );

  scs_project u_project (
    .clk  (clk),
    .rst  (rst),
    .base (base),
    .vec  (vec)
  );

  scs_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .vec    (vec),
    .done   (done),
    .result (result)
  );

`ifndef ASSERT_OFF
  // every done strobe traces back to an item taken earlier
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LATENCY))
    else $error("result without a matching item");

  // a degenerate base always reports lightlike
  a_degen_light: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |-> (result.signature == SIG_LIGHT))
    else $error("degenerate base with nonzero signature");

  // a degenerate base cannot also report a foot outside
  a_degen_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.degenerate && result.projection_outside))
    else $error("degenerate and outside both set");

  // edge items never raise triangle flags
  a_edge_flags: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.opcode == OP_EDGE, LATENCY))
      |-> (!result.degenerate && !result.projection_outside))
    else $error("edge item raised a triangle flag");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for simplex_causal_signature_unit: directed and random edges and triangles
// expected results come from an exact integer predictor kept in this file
// depends on scs_pkg and the rtl of simplex_causal_signature_unit
`timescale 1ns / 100ps

module testbench;
  import scs_pkg::*;

  // wide enough for every product the projection can form at the coordinate width in scs_pkg
  typedef logic signed [127:0] acc_t;

  typedef struct {
    scs_in_t cmd;
    bit      drain_first;
  } pending_t;

  localparam int CB = COORD_BITS;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  scs_in_t  cmd;
  logic     done;
  scs_out_t result;

  pending_t pending_items[$];
  scs_out_t expected_results[$];
  pending_t next_item;
  bit       took_item;
  int       gap_left;
  int       error_count;
  int       n_edge, n_tri, n_space, n_time, n_light, n_degen, n_outside;

  simplex_causal_signature_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // one coordinate of a packed corner; bits past the 32-bit word read as zero
  function automatic acc_t coord_at(logic [31:0] v, int k);
    logic [63:0] e;
    logic [63:0] mask;
    acc_t r;
    e    = {32'd0, v};
    mask = (64'd1 << CB) - 64'd1;
    r    = acc_t'((e >> ((3 - k) * CB)) & mask);
    return r;
  endfunction

  // sign of spatial length squared minus time length squared
  function automatic logic signed [1:0] classify_interval(acc_t v[4]);
    acc_t sp, tm;
    sp = v[1] * v[1] + v[2] * v[2] + v[3] * v[3];
    tm = v[0] * v[0];
    if (sp > tm) return SIG_SPACE;
    if (sp < tm) return SIG_TIME;
    return SIG_LIGHT;
  endfunction

  function automatic acc_t abs_of(acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  // exact causal signature of one edge or triangle
  function automatic scs_out_t predict_signature(scs_in_t c);
    logic [31:0] vx[3];
    acc_t p[3][4];
    acc_t d[4], u[4], w[4];
    acc_t dif[3];
    acc_t n, den;
    int b;
    scs_out_t r;
    r = '0;
    vx[0] = c.vertex_a;
    vx[1] = c.vertex_b;
    vx[2] = c.vertex_c;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 4; k++)
        p[i][k] = coord_at(vx[i], k);
    if (c.opcode == OP_EDGE) begin
      for (int k = 0; k < 4; k++)
        d[k] = p[1][k] - p[0][k];
      r.signature = classify_interval(d);
    end else begin
      for (int i = 0; i < 3; i++)
        dif[i] = abs_of(p[i][0] - p[(i + 1) % 3][0]);
      if (dif[0] != 0 && dif[1] != 0 && dif[2] != 0) begin
        r.signature = SIG_TIME;
      end else begin
        // base is the edge of smallest time difference, ties to the later edge
        if (dif[0] < dif[1]) b = (dif[0] < dif[2]) ? 0 : 2;
        else b = (dif[1] < dif[2]) ? 1 : 2;
        n   = 0;
        den = 0;
        for (int k = 0; k < 4; k++) begin
          u[k] = p[(b + 1) % 3][k] - p[b][k];
          w[k] = p[(b + 2) % 3][k] - p[b][k];
          n    = n + u[k] * w[k];
          den  = den + u[k] * u[k];
        end
        if (den == 0) begin
          r.degenerate = 1'b1;
          r.signature  = SIG_LIGHT;
        end else begin
          r.projection_outside = (n < 0 || n > den);
          // connecting vector scaled by the squared base length
          for (int k = 0; k < 4; k++)
            d[k] = u[k] * n - w[k] * den;
          r.signature = classify_interval(d);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pack_corner(int t, int x, int y, int z);
    logic [63:0] v;
    v = (64'(t) << (3 * CB)) | (64'(x) << (2 * CB)) | (64'(y) << CB) | 64'(z);
    return v[31:0];
  endfunction

  function automatic logic [31:0] random_corner(bit tiny);
    if (!tiny) return $urandom;
    return pack_corner($urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  // replace the time coordinate of a corner
  function automatic logic [31:0] with_time(logic [31:0] v, logic [31:0] src);
    logic [63:0] mask;
    logic [63:0] r;
    mask = ((64'd1 << CB) - 64'd1) << (3 * CB);
    r    = ({32'd0, v} & ~mask) | ({32'd0, src} & mask);
    return r[31:0];
  endfunction

  task automatic queue_item(op_t op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            bit drain);
    pending_t p;
    p.cmd.opcode   = op;
    p.cmd.vertex_a = a;
    p.cmd.vertex_b = b;
    p.cmd.vertex_c = c;
    p.drain_first  = drain;
    pending_items  = {pending_items, p};
  endtask

  // random triangle, mostly with a shared time so the projection path is taken
  task automatic queue_random_triangle(bit drain);
    logic [31:0] v[3];
    bit tiny;
    int style, i, j;
    tiny  = ($urandom_range(0, 2) == 0);
    style = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++)
      v[k] = random_corner(tiny);
    i = $urandom_range(0, 2);
    j = (i + $urandom_range(1, 2)) % 3;
    if (style >= 1 && style <= 6) begin
      v[j] = with_time(v[j], v[i]);
      if (style == 6)
        v[3 - i - j] = with_time(v[3 - i - j], v[i]);
    end else if (style == 7) begin
      v[j] = v[i];
    end else if (style == 8) begin
      for (int k = 0; k < 3; k++)
        v[k] = random_corner(1'b1);
    end
    queue_item(OP_TRIANGLE, v[0], v[1], v[2], drain);
  endtask

  // sender may idle except in back-to-back stretches and near the end
  function automatic bit idle_allowed();
    int left;
    left = pending_items.size();
    return left > 150 && ((left / 100) % 3) != 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      // item still waiting to be taken
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_items.size() == 0 ||
                 (pending_items[0].drain_first && expected_results.size() != 0)) begin
      start <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
      start    <= 1'b0;
      gap_left = $urandom_range(0, 16);
    end else begin
      next_item = pending_items.pop_front();
      cmd   <= next_item.cmd;
      start <= 1'b1;
    end
  end

  // monitor: predict accepted items, check strobed results
  always @(posedge clk) begin
    scs_out_t exp_r;
    took_item = !rst && start && !busy;
    if (took_item) begin
      exp_r = predict_signature(cmd);
      expected_results = {expected_results, exp_r};
      if (cmd.opcode == OP_EDGE) n_edge++;
      else n_tri++;
      if (exp_r.signature == SIG_SPACE) n_space++;
      else if (exp_r.signature == SIG_TIME) n_time++;
      else n_light++;
      n_degen   += exp_r.degenerate;
      n_outside += exp_r.projection_outside;
    end
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result strobed with no item outstanding");
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.signature !== exp_r.signature) begin
          $error("signature: expected %0d, got %0d", exp_r.signature, result.signature);
          error_count++;
        end
        if (result.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_r.degenerate,
                 result.degenerate);
          error_count++;
        end
        if (result.projection_outside !== exp_r.projection_outside) begin
          $error("projection_outside: expected %0b, got %0b",
                 exp_r.projection_outside, result.projection_outside);
          error_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    took_item   = 1'b0;
    gap_left    = 0;
    error_count = 0;

    // edges: zero length, extremes, pure time, lightlike
    queue_item(OP_EDGE, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_EDGE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    queue_item(OP_EDGE, 32'h0, pack_corner(255, 0, 0, 0), $urandom, 1'b0);
    queue_item(OP_EDGE, 32'hFFFF_FFFF, 32'h0, $urandom, 1'b0);
    queue_item(OP_EDGE, pack_corner(10, 10, 10, 10), pack_corner(15, 13, 14, 10),
               $urandom, 1'b0);
    queue_item(OP_EDGE, pack_corner(0, 0, 0, 0), pack_corner(1, 1, 0, 0), 32'h0, 1'b0);
    // triangles: all time differences nonzero
    queue_item(OP_TRIANGLE, pack_corner(0, 3, 4, 5), pack_corner(1, 9, 9, 9),
               pack_corner(255, 0, 0, 0), 1'b0);
    // degenerate base, and all corners equal
    queue_item(OP_TRIANGLE, pack_corner(5, 6, 7, 8), pack_corner(5, 6, 7, 8),
               pack_corner(9, 1, 2, 3), 1'b0);
    queue_item(OP_TRIANGLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // foot past either end of the base
    queue_item(OP_TRIANGLE, pack_corner(0, 0, 0, 0), pack_corner(0, 1, 0, 0),
               pack_corner(7, 5, 0, 0), 1'b0);
    queue_item(OP_TRIANGLE, pack_corner(0, 5, 0, 0), pack_corner(0, 6, 0, 0),
               pack_corner(3, 0, 0, 0), 1'b0);
    // foot inside: lightlike and spacelike connecting vectors
    queue_item(OP_TRIANGLE, pack_corner(0, 0, 0, 0), pack_corner(0, 2, 0, 0),
               pack_corner(1, 1, 1, 0), 1'b0);
    queue_item(OP_TRIANGLE, pack_corner(0, 0, 0, 0), pack_corner(0, 2, 0, 0),
               pack_corner(0, 1, 3, 0), 1'b0);
    // base selection ties
    queue_item(OP_TRIANGLE, pack_corner(4, 1, 2, 3), pack_corner(9, 7, 0, 2),
               pack_corner(9, 3, 3, 9), 1'b0);
    queue_item(OP_TRIANGLE, pack_corner(4, 1, 2, 3), pack_corner(9, 7, 0, 2),
               pack_corner(4, 3, 3, 9), 1'b0);
    queue_item(OP_TRIANGLE, pack_corner(3, 1, 2, 3), pack_corner(3, 7, 0, 2),
               pack_corner(8, 3, 3, 9), 1'b0);
    // extreme coordinates on the projection path
    queue_item(OP_TRIANGLE, 32'h0, pack_corner(0, 255, 255, 255),
               pack_corner(255, 255, 0, 255), 1'b0);
    queue_item(OP_TRIANGLE, 32'hFFFF_FFFF, pack_corner(255, 0, 0, 0), 32'h0, 1'b0);
    queue_item(OP_TRIANGLE, pack_corner(0, 255, 0, 0), pack_corner(0, 0, 255, 255),
               pack_corner(0, 0, 0, 0), 1'b0);

    // random part; the first item and one in the middle wait for an empty pipe
    for (int i = 0; i < 1000; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_item(OP_EDGE, random_corner(bit'($urandom_range(0, 1))),
                   random_corner(bit'($urandom_range(0, 1))), $urandom,
                   i == 0 || i == 500);
      else
        queue_random_triangle(i == 0 || i == 500);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_items.size() != 0 || start);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d edges and %0d triangles: %0d spacelike, %0d timelike, %0d lightlike",
             n_edge, n_tri, n_space, n_time, n_light);
    $display("triangles with degenerate base: %0d, with foot outside base: %0d",
             n_degen, n_outside);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
